### rtl/hxf_pkg.sv
// Shared types, constants and helpers for the uppercase hex formatter.
package hxf_pkg;

   localparam int MAX_WIDTH_DEFAULT = 62;

   localparam logic [1:0] MODE_32 = 2'd0;
   localparam logic [1:0] MODE_64 = 2'd1;
   localparam logic [1:0] MODE_16 = 2'd2;

   localparam logic [6:0] CH_SPACE   = 7'd32;
   localparam logic [6:0] CH_ZERO    = 7'd48;
   localparam logic [6:0] CH_UPPER_A = 7'd65;
   localparam logic [6:0] CH_UPPER_F = 7'd70;
   localparam logic [6:0] CH_NINE    = 7'd57;
   localparam logic [6:0] CH_UPPER_X = 7'd88;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_NORM,
      ST_CALC,
      ST_START,
      ST_PADL,
      ST_PFX0,
      ST_PFXX,
      ST_DIGIT
   } state_type;

   typedef enum logic [1:0] {
      SEL_SPACE,
      SEL_ZERO,
      SEL_X,
      SEL_DIGIT
   } sel_type;

   typedef struct packed {
      logic    load;
      logic    shift_norm;
      logic    calc;
      logic    emit;
      sel_type sel;
      logic    pad_dec;
      logic    dig_step;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic top_zero;
      logic ndig_one;
      logic pad_zero;
      logic pad_one;
      logic alt_nz;
      logic left;
   } status_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] c;
      if (nib < 4'd10) begin
         c = CH_ZERO + {3'd0, nib};
      end else begin
         c = CH_UPPER_A + {3'd0, nib} - 7'd10;
      end
      return c;
   endfunction

endpackage

### rtl/hxf_ctrl.sv
// Sequencing state machine: normalize, size the padding, emit the characters.
module hxf_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hxf_pkg::status_type status,
   output hxf_pkg::cmd_type    cmd
);
   import hxf_pkg::*;

   state_type state_ff;
   state_type state_in;
   state_type text_state;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign text_state = status.alt_nz ? ST_PFX0 : ST_DIGIT;

   // padding after the digits reuses ST_PADL; left flag selects where it ends
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (!status.top_zero || status.ndig_one) begin
               state_in = ST_CALC;
            end
         end
         ST_CALC: state_in = ST_START;
         ST_START: begin
            if (!status.left && !status.pad_zero) begin
               state_in = ST_PADL;
            end else begin
               state_in = text_state;
            end
         end
         ST_PADL: begin
            if (status.out_free && status.pad_one) begin
               state_in = status.left ? ST_IDLE : text_state;
            end
         end
         ST_PFX0: begin
            if (status.out_free) begin
               state_in = ST_PFXX;
            end
         end
         ST_PFXX: begin
            if (status.out_free) begin
               state_in = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (status.out_free && status.ndig_one) begin
               state_in = (status.left && !status.pad_zero) ? ST_PADL : ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      cmd.sel   = SEL_SPACE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_NORM: cmd.shift_norm = status.top_zero && !status.ndig_one;
         ST_CALC: cmd.calc = 1'b1;
         ST_START: cmd.sel = SEL_SPACE;
         ST_PADL: begin
            cmd.emit    = status.out_free;
            cmd.pad_dec = status.out_free;
            cmd.sel     = SEL_SPACE;
         end
         ST_PFX0: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_ZERO;
         end
         ST_PFXX: begin
            cmd.emit = status.out_free;
            cmd.sel  = SEL_X;
         end
         ST_DIGIT: begin
            cmd.emit     = status.out_free;
            cmd.dig_step = status.out_free;
            cmd.sel      = SEL_DIGIT;
         end
         default: cmd = '0;
      endcase
   end

endmodule

### rtl/hxf_dp.sv
// Datapath: value shifter, digit/pad/total counters and the output register.
module hxf_dp #(
   parameter int MAX_WIDTH = hxf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  hxf_pkg::cmd_type    cmd,
   output hxf_pkg::status_type status,
   input  logic [63:0]         req_value,
   input  logic [1:0]          req_length_mode,
   input  logic [5:0]          req_field_width,
   input  logic                req_alt_prefix,
   input  logic                req_left_justify,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [6:0]          rsp_char_out,
   output logic                rsp_last_char
);
   import hxf_pkg::*;

   localparam int CntW = $clog2(MAX_WIDTH + 1);
   localparam logic [5:0] MaxW6 = 6'(MAX_WIDTH);

   logic [63:0]     val_ff, val_in;
   logic [4:0]      ndig_ff, ndig_in;
   logic [CntW-1:0] width_ff, width_in;
   logic [CntW-1:0] pad_ff, pad_in;
   logic [CntW-1:0] total_ff, total_in;
   logic            alt_ff, left_ff, nz_ff;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [6:0]      rsp_char_ff, rsp_char_in;
   logic            rsp_last_ff, rsp_last_in;
   logic [5:0]      width_sat;
   logic [CntW-1:0] tlen;

   assign width_sat = (req_field_width > MaxW6) ? MaxW6 : req_field_width;
   assign tlen = CntW'(ndig_ff) + ((alt_ff && nz_ff) ? CntW'(2) : CntW'(0));

   always_comb begin
      val_in   = val_ff;
      ndig_in  = ndig_ff;
      width_in = width_ff;
      pad_in   = pad_ff;
      total_in = total_ff;
      if (cmd.load) begin
         case (req_length_mode)
            MODE_64: begin
               val_in  = req_value;
               ndig_in = 5'd16;
            end
            MODE_16: begin
               val_in  = {req_value[15:0], 48'd0};
               ndig_in = 5'd4;
            end
            default: begin
               val_in  = {req_value[31:0], 32'd0};
               ndig_in = 5'd8;
            end
         endcase
         width_in = CntW'(width_sat);
      end
      if (cmd.shift_norm || cmd.dig_step) begin
         val_in  = {val_ff[59:0], 4'd0};
         ndig_in = ndig_ff - 5'd1;
      end
      if (cmd.calc) begin
         pad_in   = (width_ff > tlen) ? (width_ff - tlen) : '0;
         total_in = (width_ff > tlen) ? width_ff : tlen;
      end
      if (cmd.pad_dec) begin
         pad_in = pad_ff - CntW'(1);
      end
      if (cmd.emit) begin
         total_in = total_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      val_ff   <= val_in;
      ndig_ff  <= ndig_in;
      width_ff <= width_in;
      pad_ff   <= pad_in;
      total_ff <= total_in;
      if (cmd.load) begin
         alt_ff  <= req_alt_prefix;
         left_ff <= req_left_justify;
         nz_ff   <= |val_in;
      end
   end

   always_comb begin
      case (cmd.sel)
         SEL_SPACE: rsp_char_in = CH_SPACE;
         SEL_ZERO:  rsp_char_in = CH_ZERO;
         SEL_X:     rsp_char_in = CH_UPPER_X;
         SEL_DIGIT: rsp_char_in = hex_char(val_ff[63:60]);
         default:   rsp_char_in = CH_SPACE;
      endcase
      rsp_last_in  = (total_ff == CntW'(1));
      rsp_valid_in = cmd.emit || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         rsp_char_ff <= rsp_char_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_out  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign status.top_zero = (val_ff[63:60] == 4'd0);
   assign status.ndig_one = (ndig_ff == 5'd1);
   assign status.pad_zero = (pad_ff == '0);
   assign status.pad_one  = (pad_ff == CntW'(1));
   assign status.alt_nz   = alt_ff && nz_ff;
   assign status.left     = left_ff;

endmodule

### rtl/hex_uppercase_formatter.sv
// Top level of the printf %X formatter: one request in, a run of ASCII characters out.
// Before the first character, leading-zero nibbles are dropped one per cycle; the
// controller then leaves normalization, sizes the padding, dispatches the first
// character and registers it in the output register.
// Throughput: one character per cycle while rsp_ready is high; a new request is
// accepted only after the last character of the previous one has been emitted.
// Reset clears the state machine and the output valid; no request is in flight after it.
module hex_uppercase_formatter #(
   parameter int MAX_WIDTH = hxf_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_value,
   input  logic [1:0]  req_length_mode,
   input  logic [5:0]  req_field_width,
   input  logic        req_alt_prefix,
   input  logic        req_left_justify,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [6:0]  rsp_char_out,
   output logic        rsp_last_char
);
   import hxf_pkg::*;

   cmd_type    cmd;
   status_type status;

   hxf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   hxf_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_value        (req_value),
      .req_length_mode  (req_length_mode),
      .req_field_width  (req_field_width),
      .req_alt_prefix   (req_alt_prefix),
      .req_left_justify (req_left_justify),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_out     (rsp_char_out),
      .rsp_last_char    (rsp_last_char)
   );

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("controller stayed idle after accepting a request");

   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> status.out_free)
      else $error("character emitted over an untaken one");

   a_legal_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_char_out == CH_SPACE || rsp_char_out == CH_UPPER_X ||
                     (rsp_char_out >= CH_ZERO && rsp_char_out <= CH_NINE) ||
                     (rsp_char_out >= CH_UPPER_A && rsp_char_out <= CH_UPPER_F)))
      else $error("illegal character on the response");

endmodule

### dv/tb_top.sv
// Self-checking testbench for hex_uppercase_formatter: predicts %X text per request.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hxf_pkg::*;

   localparam int         MAX_W        = MAX_WIDTH_DEFAULT;
   localparam logic [1:0] MODE_UNUSED  = 2'd3;
   localparam int         N_RANDOM     = 300;
   localparam int         QUIET_TAIL   = 40;
   localparam int         HOLD_AT      = 60;
   localparam int         HOLD_CYCLES  = 400;
   localparam int         DRAIN_CYCLES = 100;
   localparam int         CYCLE_LIMIT  = 1000000;
   localparam int         MAX_PRINTS   = 50;

   typedef struct {
      logic [63:0] value;
      logic [1:0]  mode;
      logic [5:0]  width;
      logic        alt;
      logic        left;
      logic        drain;
   } hex_req_type;

   typedef struct {
      logic [6:0] ch;
      logic       last;
   } hex_char_type;

   logic        clock            = 1'b0;
   logic        reset            = 1'b1;
   logic        req_valid        = 1'b0;
   logic        req_ready;
   logic [63:0] req_value        = '0;
   logic [1:0]  req_length_mode  = MODE_32;
   logic [5:0]  req_field_width  = '0;
   logic        req_alt_prefix   = 1'b0;
   logic        req_left_justify = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready        = 1'b0;
   logic [6:0]  rsp_char_out;
   logic        rsp_last_char;

   hex_req_type  pending_reqs[$];
   hex_char_type exp_chars[$];
   hex_req_type  cur_req;
   int        n_accepted = 0;
   int        n_errors   = 0;
   int        gap_left   = 0;
   int        stall_left = 0;
   int        cycles     = 0;
   logic      hold_off   = 1'b0;

   hex_uppercase_formatter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_length_mode  (req_length_mode),
      .req_field_width  (req_field_width),
      .req_alt_prefix   (req_alt_prefix),
      .req_left_justify (req_left_justify),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_char_out     (rsp_char_out),
      .rsp_last_char    (rsp_last_char)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit in_final_stretch();
      return pending_reqs.size() < QUIET_TAIL;
   endfunction

   task automatic report_mismatch(input string msg);
      if (n_errors < MAX_PRINTS) begin
         $display("MISMATCH @%0t: %s", $realtime, msg);
      end
      n_errors++;
   endtask

   // Build the expected character run for one request.
   task automatic queue_hex_text(input hex_req_type r);
      logic [63:0] v;
      logic [63:0] t;
      logic [3:0]  nib;
      logic [6:0]  text[18];
      int          width;
      int          ndig;
      int          tlen;
      int          pad;
      int          total;
      int          k;
      hex_char_type c;
      ndig = 0;
      tlen = 0;
      pad  = 0;
      case (r.mode)
         MODE_64: v = r.value;
         MODE_16: v = r.value & 64'h0000_0000_0000_FFFF;
         default: v = r.value & 64'h0000_0000_FFFF_FFFF;
      endcase
      width = (int'(r.width) > MAX_W) ? MAX_W : int'(r.width);
      if (v == '0) begin
         text[tlen++] = CH_ZERO;
      end else begin
         t = v;
         while (t != '0 && ndig < 16) begin
            ndig++;
            t = t >> 4;
         end
         if (r.alt) begin
            text[tlen++] = CH_ZERO;
            text[tlen++] = CH_UPPER_X;
         end
         for (int d = ndig - 1; d >= 0; d--) begin
            nib = v[d*4 +: 4];
            text[tlen++] = (nib < 4'd10) ? (CH_ZERO + 7'(nib)) : (CH_UPPER_A + 7'(nib) - 7'd10);
         end
      end
      if (width > tlen) pad = width - tlen;
      total = pad + tlen;
      k = 0;
      if (!r.left) begin
         for (int i = 0; i < pad; i++) begin
            k++;
            c.ch = CH_SPACE;
            c.last = (k == total);
            exp_chars.push_back(c);
         end
      end
      for (int i = 0; i < tlen; i++) begin
         k++;
         c.ch = text[i];
         c.last = (k == total);
         exp_chars.push_back(c);
      end
      if (r.left) begin
         for (int i = 0; i < pad; i++) begin
            k++;
            c.ch = CH_SPACE;
            c.last = (k == total);
            exp_chars.push_back(c);
         end
      end
   endtask

   task automatic push_req(input logic [63:0] value, input logic [1:0] mode,
                           input logic [5:0] width, input logic alt, input logic left,
                           input logic drain);
      hex_req_type r;
      r.value = value;
      r.mode  = mode;
      r.width = width;
      r.alt   = alt;
      r.left  = left;
      r.drain = drain;
      pending_reqs.push_back(r);
   endtask

   // Request driver
   always @(posedge clock) begin : drv
      logic offer;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            queue_hex_text(cur_req);
            n_accepted++;
            offer = 1'b0;
            if (!in_final_stretch() && $urandom_range(0, 3) == 0) begin
               gap_left = $urandom_range(1, 7);
            end
         end
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_reqs.size() > 0 &&
                         !(pending_reqs[0].drain && exp_chars.size() > 0)) begin
               cur_req = pending_reqs.pop_front();
               offer = 1'b1;
               req_value        <= cur_req.value;
               req_length_mode  <= cur_req.mode;
               req_field_width  <= cur_req.width;
               req_alt_prefix   <= cur_req.alt;
               req_left_justify <= cur_req.left;
            end
         end
         req_valid <= offer;
      end
   end

   // Character monitor and receiver back-pressure
   always @(posedge clock) begin : mon
      hex_char_type e;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (exp_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%h last=%b",
                                         rsp_char_out, rsp_last_char));
            end else begin
               e = exp_chars.pop_front();
               if (rsp_char_out !== e.ch) begin
                  report_mismatch($sformatf("char_out 0x%h, expected 0x%h",
                                            rsp_char_out, e.ch));
               end
               if (rsp_last_char !== e.last) begin
                  report_mismatch($sformatf("last_char %b, expected %b",
                                            rsp_last_char, e.last));
               end
            end
         end
         if (hold_off) begin
            rsp_ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (!in_final_stretch() && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Long receiver hold-off while the driver keeps offering requests
   initial begin
      while (n_accepted < HOLD_AT) @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      logic [63:0] v;
      int          sh;
      logic [5:0]  w;

      // zero value, prefix suppressed, width extremes and saturation
      push_req(64'h0, MODE_32, 6'd0, 1'b1, 1'b0, 1'b0);
      push_req(64'h0, MODE_64, 6'd1, 1'b0, 1'b1, 1'b0);
      push_req(64'h0, MODE_16, 6'd63, 1'b1, 1'b0, 1'b0);
      push_req(64'h0, MODE_32, 6'd63, 1'b0, 1'b1, 1'b0);
      // truncation per length mode, unused mode as 32-bit
      push_req('1, MODE_64, 6'd0, 1'b1, 1'b0, 1'b0);
      push_req('1, MODE_32, 6'd0, 1'b1, 1'b0, 1'b0);
      push_req('1, MODE_16, 6'd0, 1'b1, 1'b1, 1'b0);
      push_req('1, MODE_UNUSED, 6'd0, 1'b0, 1'b0, 1'b0);
      push_req(64'hFFFF_FFFF_0000_0000, MODE_32, 6'd4, 1'b1, 1'b0, 1'b0);
      push_req(64'h0000_0000_ABCD_0000, MODE_16, 6'd3, 1'b1, 1'b1, 1'b0);
      push_req(64'h1234_5678_9ABC_DEF0, MODE_UNUSED, 6'd12, 1'b1, 1'b0, 1'b0);
      // all digits, wide fields both justifications
      push_req(64'hFEDC_BA98_7654_3210, MODE_64, 6'd62, 1'b1, 1'b1, 1'b0);
      push_req(64'h0123_4567_89AB_CDEF, MODE_64, 6'd20, 1'b0, 1'b0, 1'b0);
      push_req(64'h8000_0000_0000_0000, MODE_64, 6'd63, 1'b1, 1'b0, 1'b0);
      // width below, equal to and just above the text length
      push_req(64'h12345, MODE_32, 6'd2, 1'b0, 1'b0, 1'b0);
      push_req(64'h12345, MODE_32, 6'd5, 1'b0, 1'b1, 1'b0);
      push_req(64'h1, MODE_32, 6'd3, 1'b1, 1'b0, 1'b0);
      push_req(64'h1, MODE_32, 6'd4, 1'b1, 1'b1, 1'b0);
      push_req(64'hA, MODE_16, 6'd62, 1'b0, 1'b0, 1'b0);
      push_req(64'hF, MODE_16, 6'd1, 1'b0, 1'b1, 1'b0);

      for (int i = 0; i < N_RANDOM; i++) begin
         v = {$urandom, $urandom};
         sh = $urandom_range(0, 64);
         if (sh == 64 || $urandom_range(0, 15) == 0) v = '0;
         else v = v >> sh;
         if ($urandom_range(0, 3) != 0) w = 6'($urandom_range(0, 24));
         else w = 6'($urandom_range(0, 63));
         push_req(v, 2'($urandom_range(0, 3)), w, 1'($urandom), 1'($urandom),
                  (i == 0 || i == N_RANDOM / 2));
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() > 0 || req_valid || exp_chars.size() > 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (exp_chars.size() != 0) begin
         report_mismatch($sformatf("%0d expected chars never arrived", exp_chars.size()));
      end
      if (n_errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

### hex_uppercase_formatter.f
rtl/hxf_pkg.sv
rtl/hxf_ctrl.sv
rtl/hxf_dp.sv
rtl/hex_uppercase_formatter.sv
dv/tb_top.sv
